@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define VFR_ASSERT_IMPLY(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (prop)) \
        else $error("implication check failed");

// next-cycle implication, checked outside reset
`define VFR_ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (prop)) \
        else $error("next-cycle check failed");

`endif

@@ hw/rtl/vfr_pkg.sv @@
// shared constants and types of the velocity frame receiver
package vfr_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned POS_W       = 4;
    localparam int unsigned SPEED_W     = 16;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned S_TDATA_W   = 16;
    localparam int unsigned M_TDATA_W   = 56;
    localparam int unsigned SPEED_SR_W  = 3 * SPEED_W;
    localparam int unsigned M_USED_W    = STATUS_W + SPEED_SR_W;

    // frame layout
    localparam logic [POS_W-1:0] SPEED_FIRST = 4'd3;
    localparam logic [POS_W-1:0] SPEED_LAST  = 4'd8;
    localparam logic [POS_W-1:0] CHK_POS     = 4'd9;
    localparam logic [POS_W-1:0] TAIL_POS    = 4'd10;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'd123;
    localparam logic [BYTE_W-1:0] TAIL_RESET   = 8'd125;

    typedef enum logic [0:0] {
        REG_HEADER = 1'b0,
        REG_TAIL   = 1'b1
    } cfg_reg_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BAD_TAIL = 2'd1,
        STATUS_BAD_SUM  = 2'd2
    } frame_status_t;

endpackage

@@ hw/rtl/velocity_frame_receiver.sv @@
// velocity frame receiver: header/tail framed 11-byte command parser with xor checksum
//
//  channel   | direction | tdata fields (lsb first)                       | tuser
//  ----------+-----------+------------------------------------------------+------
//  s_ stream | in        | rx_byte[7:0], accept_enable[8], zero pad        | none
//  m_ stream | out       | frame_status[1:0], speed_x, speed_y, speed_z    | none
//  cfg write | in        | cfg_addr 0 header_byte, 1 tail_byte             | none
//
//  one item per cycle sustained while m_tready does not stall the output; an item enters
//  the input register, then one pass of logic updates the frame state and loads the result register
//  synchronous active-low reset clears position and valids and loads the header/tail registers with their defaults
//  a stalled result holds in the output register; the input register keeps taking items
//  as long as it is empty or the output register is empty or being drained
module velocity_frame_receiver (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic                              cfg_addr,
    input  logic [vfr_pkg::BYTE_W-1:0]        cfg_wdata,
    // input item stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [vfr_pkg::S_TDATA_W-1:0]     s_tdata,   // rx_byte[7:0], accept_enable[8]
    // result item stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [vfr_pkg::M_TDATA_W-1:0]     m_tdata    // status[1:0], x[17:2], y[33:18], z[49:34]
);
    import vfr_pkg::*;

    // configuration registers
    logic [BYTE_W-1:0] header_reg;
    logic [BYTE_W-1:0] tail_reg;

    // input register
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_en_reg;

    // frame state
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [BYTE_W-1:0]     xor_reg, xor_next;
    logic                  chk_ok_reg, chk_ok_next;
    logic [SPEED_SR_W-1:0] speed_sr_reg, speed_sr_next;

    // result register
    logic                 out_valid_reg, out_valid_next;
    logic [M_USED_W-1:0]  out_data_reg, out_data_next;

    logic          out_can_take;
    logic          proc;
    logic          frame_done;
    frame_status_t status;

    // the output register can load when empty or when its item leaves this cycle
    assign out_can_take = !out_valid_reg || m_tready;
    assign s_tready     = !in_valid_reg || out_can_take;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = {{(M_TDATA_W-M_USED_W){1'b0}}, out_data_reg};

    // a disabled byte passes through the input register with no effect
    assign proc       = in_valid_reg && out_can_take && in_en_reg;
    assign frame_done = proc && (pos_reg == TAIL_POS);

    always_comb begin
        pos_next      = pos_reg;
        xor_next      = xor_reg;
        chk_ok_next   = chk_ok_reg;
        speed_sr_next = speed_sr_reg;
        status        = STATUS_OK;

        if (proc) begin
            // running checksum over bytes 0..8, compared when byte 9 arrives
            if (pos_reg == '0) begin
                xor_next = in_byte_reg;
            end else if (pos_reg <= SPEED_LAST) begin
                xor_next = xor_reg ^ in_byte_reg;
            end
            if (pos_reg == CHK_POS) begin
                chk_ok_next = (in_byte_reg == xor_reg);
            end
            // bytes 3..8 shift in high byte first, leaving x on top and z at the bottom
            if (pos_reg >= SPEED_FIRST && pos_reg <= SPEED_LAST) begin
                speed_sr_next = {speed_sr_reg[SPEED_SR_W-BYTE_W-1:0], in_byte_reg};
            end

            // idle bytes stay at position zero unless they match the header
            if (frame_done) begin
                pos_next = '0;
            end else if (pos_reg != '0 || in_byte_reg == header_reg) begin
                pos_next = pos_reg + 4'd1;
            end else begin
                pos_next = '0;
            end
        end

        // tail check wins over checksum check
        priority if (in_byte_reg != tail_reg) begin
            status = STATUS_BAD_TAIL;
        end else if (!chk_ok_reg) begin
            status = STATUS_BAD_SUM;
        end else begin
            status = STATUS_OK;
        end
    end

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        if (out_can_take) begin
            out_valid_next = frame_done;
            if (status == STATUS_OK) begin
                // x lands right above the status, then y, then z
                out_data_next = {speed_sr_reg[SPEED_W-1:0],
                                 speed_sr_reg[2*SPEED_W-1:SPEED_W],
                                 speed_sr_reg[SPEED_SR_W-1:2*SPEED_W],
                                 status};
            end else begin
                out_data_next = {{SPEED_SR_W{1'b0}}, status};
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg    <= HEADER_RESET;
            tail_reg      <= TAIL_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_reg_t'(cfg_addr))
                    REG_HEADER: header_reg <= cfg_wdata;
                    REG_TAIL:   tail_reg   <= cfg_wdata;
                    default:    header_reg <= header_reg;
                endcase
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_byte_reg <= s_tdata[BYTE_W-1:0];
            in_en_reg   <= s_tdata[BYTE_W];
        end
        xor_reg      <= xor_next;
        chk_ok_reg   <= chk_ok_next;
        speed_sr_reg <= speed_sr_next;
        out_data_reg <= out_data_next;
    end

endmodule

@@ hw/rtl/vfr_checker.sv @@
// port-level checker for the velocity frame receiver, bound to the top level
`include "assert_macros.svh"

module vfr_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              cfg_wr_en,
    input logic                              cfg_addr,
    input logic [vfr_pkg::BYTE_W-1:0]        cfg_wdata,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [vfr_pkg::S_TDATA_W-1:0]     s_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [vfr_pkg::M_TDATA_W-1:0]     m_tdata
);
    import vfr_pkg::*;

    logic [STATUS_W-1:0] st;
    logic                bad;
    logic                speeds_zero;

    assign st          = m_tdata[STATUS_W-1:0];
    assign bad         = (st != STATUS_OK);
    assign speeds_zero = (m_tdata[M_USED_W-1:STATUS_W] == '0);

    // only the three status codes appear
    `VFR_ASSERT_IMPLY(a_status_code, aclk, aresetn, m_tvalid,
        st == STATUS_OK || st == STATUS_BAD_TAIL || st == STATUS_BAD_SUM)
    // rejected frames carry zero speeds
    `VFR_ASSERT_IMPLY(a_bad_zero, aclk, aresetn, m_tvalid && bad, speeds_zero)
    // an empty output side never blocks the input
    `VFR_ASSERT_IMPLY(a_ready_free, aclk, aresetn, !m_tvalid, s_tready)
    // a stalled result item holds
    `VFR_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata))

endmodule

bind velocity_frame_receiver vfr_checker u_vfr_checker (.*);
